// ===== design/tsgd_pkg.sv =====
// tsgd_pkg: shared types, codes and the edge-area function of the swipe detector
`default_nettype none

package tsgd_pkg;

    localparam int COORD_W   = 11;
    localparam int ROOT_IN_W = 23;
    localparam int ROOT_W    = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_A_W   = 16;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] CFG_VEDGE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEDGE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VERT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HORZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 3'd6;

    localparam logic [1:0] EV_PRESS    = 2'd0;
    localparam logic [1:0] EV_PRESSING = 2'd1;
    localparam logic [1:0] EV_RELEASE  = 2'd2;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;
        logic [3:0]         first_area;
        logic [3:0]         last_area;
        logic [2:0]         swipe_dir;
        logic [ROOT_W-1:0]  travel_px;
        logic [31:0]        elapsed_ms;
        logic               is_short;
        logic               is_slow;
    } t_event;

    // bit0 top, bit1 bottom, bit2 left, bit3 right
    function automatic logic [3:0] edge_bits(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] vedge,
        input logic [COORD_W-1:0] hedge,
        input logic [COORD_W:0]   w,
        input logic [COORD_W:0]   h
    );
        logic signed [COORD_W+1:0] rem_x;
        logic signed [COORD_W+1:0] rem_y;
        rem_y = $signed({1'b0, h}) - $signed({2'b00, y});
        rem_x = $signed({1'b0, w}) - $signed({2'b00, x});
        edge_bits = {rem_x < $signed({2'b00, hedge}), x < hedge,
                     rem_y < $signed({2'b00, vedge}), y < vedge};
    endfunction

endpackage

`default_nettype wire

// ===== design/tsgd_sample_if.sv =====
// tsgd_sample_if: touch sample channel
`default_nettype none

interface tsgd_sample_if;
    logic        valid;
    logic        ready;
    logic        pressed;
    logic [10:0] touch_x;
    logic [10:0] touch_y;
    logic [31:0] now_ms;

    modport source (output valid, pressed, touch_x, touch_y, now_ms, input ready);
    modport sink   (input valid, pressed, touch_x, touch_y, now_ms, output ready);
endinterface

`default_nettype wire

// ===== design/tsgd_event_if.sv =====
// tsgd_event_if: gesture event channel
`default_nettype none

interface tsgd_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [10:0] first_x;
    logic [10:0] first_y;
    logic [10:0] last_x;
    logic [10:0] last_y;
    logic [3:0]  first_area;
    logic [3:0]  last_area;
    logic [2:0]  swipe_dir;
    logic [11:0] travel_px;
    logic [31:0] elapsed_ms;
    logic        is_short;
    logic        is_slow;

    modport source (output valid, event_kind, first_x, first_y, last_x, last_y,
                    first_area, last_area, swipe_dir, travel_px, elapsed_ms,
                    is_short, is_slow, input ready);
    modport sink   (input valid, event_kind, first_x, first_y, last_x, last_y,
                    first_area, last_area, swipe_dir, travel_px, elapsed_ms,
                    is_short, is_slow, output ready);
endinterface

`default_nettype wire

// ===== design/touch_swipe_gesture_detector.sv =====
// touch_swipe_gesture_detector: top level, sample sequencer with shared multiplier
// sequence: a press or unmoved point goes from S_LOAD to S_OUT, a moved point
//   through S_SQX, S_SQY, S_TAN, S_ROOT (square root wait) and S_SPD to S_OUT
// throughput: one sample at a time, next sample taken once the event is loaded
//   into the output register; samples that cause no event are dropped while idle
// reset: synchronous active low, clears gesture state and output valid, sets the
//   configuration registers to their default values
`default_nettype none

module touch_swipe_gesture_detector
    import tsgd_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tsgd_sample_if.sink               i_sample,
    tsgd_event_if.source              o_event,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [COORD_W:0] SCR_W = (COORD_W+1)'(SCREEN_WIDTH);
    localparam logic [COORD_W:0] SCR_H = (COORD_W+1)'(SCREEN_HEIGHT);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_SQX  = 8'b0000_0100,
        S_SQY  = 8'b0000_1000,
        S_TAN  = 8'b0001_0000,
        S_ROOT = 8'b0010_0000,
        S_SPD  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic [COORD_W-1:0] r_cfg_vedge;
    logic [COORD_W-1:0] r_cfg_hedge;
    logic [COORD_W-1:0] r_cfg_min_vert;
    logic [COORD_W-1:0] r_cfg_min_horz;
    logic [13:0]        r_cfg_tan;
    logic [15:0]        r_cfg_slow;
    logic [15:0]        r_cfg_short;

    // gesture state
    logic               r_active;
    logic [31:0]        r_start_tick;
    logic [COORD_W-1:0] r_start_x;
    logic [COORD_W-1:0] r_start_y;
    logic [COORD_W-1:0] r_stop_x;
    logic [COORD_W-1:0] r_stop_y;
    logic [3:0]         r_start_area;
    logic [2:0]         r_dir;
    logic [ROOT_W-1:0]  r_dist;
    logic               r_slow;

    // sample and working registers
    logic               r_touched;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [31:0]        r_now;
    logic [1:0]         r_kind;
    logic [31:0]        r_elapsed;
    logic               r_short;
    logic signed [COORD_W:0] r_dx;
    logic signed [COORD_W:0] r_dy;
    logic [ROOT_IN_W-1:0]    r_acc;
    logic               r_vert;

    logic               r_out_valid;
    t_event             r_evt;

    logic               w_touched;
    logic               w_in_xfer;
    logic               w_out_xfer;
    logic               w_load;
    logic [COORD_W-1:0] w_new_x;
    logic [COORD_W-1:0] w_new_y;
    logic signed [COORD_W:0] w_dx;
    logic signed [COORD_W:0] w_dy;
    logic signed [COORD_W:0] w_ndx;
    logic signed [COORD_W:0] w_ndy;
    logic [COORD_W-1:0] w_ax;
    logic [COORD_W-1:0] w_ay;
    logic [31:0]        w_elapsed;
    logic signed [COORD_W:0] w_minv;
    logic signed [COORD_W:0] w_minh;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_prod;
    logic               w_root_start;
    logic               w_root_done;
    logic [ROOT_W-1:0]  w_root;

    assign w_touched = i_sample.pressed
                       && ({1'b0, i_sample.touch_x} < SCR_W)
                       && ({1'b0, i_sample.touch_y} < SCR_H);
    assign i_sample.ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_sample.valid && i_sample.ready;
    assign w_out_xfer = r_out_valid && o_event.ready;
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || o_event.ready);

    assign w_new_x   = r_touched ? r_x : r_stop_x;
    assign w_new_y   = r_touched ? r_y : r_stop_y;
    assign w_dx      = $signed({1'b0, w_new_x}) - $signed({1'b0, r_start_x});
    assign w_dy      = $signed({1'b0, w_new_y}) - $signed({1'b0, r_start_y});
    assign w_elapsed = r_now - r_start_tick;

    assign w_ndx = -r_dx;
    assign w_ndy = -r_dy;
    assign w_ax  = r_dx[COORD_W] ? w_ndx[COORD_W-1:0] : r_dx[COORD_W-1:0];
    assign w_ay  = r_dy[COORD_W] ? w_ndy[COORD_W-1:0] : r_dy[COORD_W-1:0];
    assign w_minv = $signed({1'b0, r_cfg_min_vert});
    assign w_minh = $signed({1'b0, r_cfg_min_horz});

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_SQX: begin
                w_mul_a = MUL_A_W'(w_ax);
                w_mul_b = MUL_B_W'(w_ax);
            end
            S_SQY: begin
                w_mul_a = MUL_A_W'(w_ay);
                w_mul_b = MUL_B_W'(w_ay);
            end
            S_TAN: begin
                w_mul_a = MUL_A_W'(r_cfg_tan);
                w_mul_b = MUL_B_W'(w_ax);
            end
            default: begin
                w_mul_a = r_cfg_slow;
                w_mul_b = r_elapsed;
            end
        endcase
    end

    assign w_prod       = MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);
    assign w_root_start = (r_state == S_TAN);

    tsgd_isqrt u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (r_acc),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_vedge    <= 11'd20;
            r_cfg_hedge    <= 11'd20;
            r_cfg_min_vert <= 11'd50;
            r_cfg_min_horz <= 11'd50;
            r_cfg_tan      <= 14'd256;
            r_cfg_slow     <= 16'd256;
            r_cfg_short    <= 16'd200;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VEDGE:    r_cfg_vedge    <= i_cfg_data[COORD_W-1:0];
                CFG_HEDGE:    r_cfg_hedge    <= i_cfg_data[COORD_W-1:0];
                CFG_MIN_VERT: r_cfg_min_vert <= i_cfg_data[COORD_W-1:0];
                CFG_MIN_HORZ: r_cfg_min_horz <= i_cfg_data[COORD_W-1:0];
                CFG_TAN:      r_cfg_tan      <= i_cfg_data[13:0];
                CFG_SLOW:     r_cfg_slow     <= i_cfg_data;
                CFG_SHORT:    r_cfg_short    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_active     <= 1'b0;
            r_start_tick <= '0;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_stop_x     <= '0;
            r_stop_y     <= '0;
            r_start_area <= '0;
            r_dir        <= DIR_NONE;
            r_dist       <= '0;
            r_slow       <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && (w_touched || r_active)) begin
                        r_touched <= w_touched;
                        r_x       <= i_sample.touch_x;
                        r_y       <= i_sample.touch_y;
                        r_now     <= i_sample.now_ms;
                        r_state   <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_stop_x <= w_new_x;
                    r_stop_y <= w_new_y;
                    if (!r_active) begin
                        r_active     <= 1'b1;
                        r_start_tick <= r_now;
                        r_start_x    <= w_new_x;
                        r_start_y    <= w_new_y;
                        r_start_area <= edge_bits(w_new_x, w_new_y, r_cfg_vedge,
                                                  r_cfg_hedge, SCR_W, SCR_H);
                        r_kind       <= EV_PRESS;
                        r_elapsed    <= '0;
                        r_short      <= 1'b0;
                        r_state      <= S_OUT;
                    end else begin
                        r_kind    <= r_touched ? EV_PRESSING : EV_RELEASE;
                        r_elapsed <= w_elapsed;
                        r_short   <= w_elapsed < 32'(r_cfg_short);
                        r_dx      <= w_dx;
                        r_dy      <= w_dy;
                        r_state   <= (w_dx != '0 || w_dy != '0) ? S_SQX : S_OUT;
                    end
                end
                S_SQX: begin
                    r_acc   <= w_prod[ROOT_IN_W-1:0];
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_acc   <= r_acc + w_prod[ROOT_IN_W-1:0];
                    r_state <= S_TAN;
                end
                S_TAN: begin
                    r_vert  <= (r_dx == '0)
                               || (MUL_P_W'({w_ay, 8'h00}) > w_prod);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (w_root_done) begin
                        r_dist  <= w_root;
                        r_state <= S_SPD;
                    end
                end
                S_SPD: begin
                    r_slow <= MUL_P_W'({r_dist, 8'h00}) < w_prod;
                    if (r_vert) begin
                        if (r_dy > w_minv) begin
                            r_dir <= DIR_DOWN;
                        end else if (r_dy < -w_minv) begin
                            r_dir <= DIR_UP;
                        end
                    end else begin
                        if (r_dx > w_minh) begin
                            r_dir <= DIR_RIGHT;
                        end else if (r_dx < -w_minh) begin
                            r_dir <= DIR_LEFT;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                        if (r_kind == EV_RELEASE) begin
                            r_active     <= 1'b0;
                            r_start_tick <= '0;
                            r_start_x    <= '0;
                            r_start_y    <= '0;
                            r_stop_x     <= '0;
                            r_stop_y     <= '0;
                            r_start_area <= '0;
                            r_dir        <= DIR_NONE;
                            r_dist       <= '0;
                            r_slow       <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_evt.event_kind <= r_kind;
            r_evt.first_x    <= r_start_x;
            r_evt.first_y    <= r_start_y;
            r_evt.last_x     <= r_stop_x;
            r_evt.last_y     <= r_stop_y;
            r_evt.first_area <= r_start_area;
            r_evt.last_area  <= edge_bits(r_stop_x, r_stop_y, r_cfg_vedge,
                                          r_cfg_hedge, SCR_W, SCR_H);
            r_evt.swipe_dir  <= r_dir;
            r_evt.travel_px  <= r_dist;
            r_evt.elapsed_ms <= r_elapsed;
            r_evt.is_short   <= r_short;
            r_evt.is_slow    <= r_slow;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_kind = r_evt.event_kind;
    assign o_event.first_x    = r_evt.first_x;
    assign o_event.first_y    = r_evt.first_y;
    assign o_event.last_x     = r_evt.last_x;
    assign o_event.last_y     = r_evt.last_y;
    assign o_event.first_area = r_evt.first_area;
    assign o_event.last_area  = r_evt.last_area;
    assign o_event.swipe_dir  = r_evt.swipe_dir;
    assign o_event.travel_px  = r_evt.travel_px;
    assign o_event.elapsed_ms = r_evt.elapsed_ms;
    assign o_event.is_short   = r_evt.is_short;
    assign o_event.is_slow    = r_evt.is_slow;

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_root_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_state == S_ROOT))
        else $error("square root finished outside its wait state");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_kind == EV_RELEASE && (!r_out_valid || o_event.ready))
        |=> (!r_active && r_dir == DIR_NONE && r_dist == '0))
        else $error("gesture state kept after release");

    a_press_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_evt.event_kind == EV_PRESS)
        |-> (r_evt.elapsed_ms == '0 && r_evt.swipe_dir == DIR_NONE && !r_evt.is_slow))
        else $error("press event with nonzero motion fields");
`endif

endmodule

`default_nettype wire

// ===== design/tsgd_isqrt.sv =====
// tsgd_isqrt: iterative floor square root, one result bit per pass, one pass a cycle
`default_nettype none

module tsgd_isqrt
    import tsgd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [ROOT_IN_W-1:0] i_value,
    output logic                      o_done,
    output logic [ROOT_W-1:0]         o_root
);

    logic                 r_busy;
    logic                 r_done;
    logic [ROOT_IN_W-1:0] r_rem;
    logic [ROOT_IN_W-1:0] r_res;
    logic [ROOT_IN_W-1:0] r_bit;
    logic [ROOT_IN_W-1:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_res <= '0;
            r_bit <= {1'b1, {(ROOT_IN_W-1){1'b0}}};
        end else if (r_busy) begin
            if (r_rem >= w_trial) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== tb/tb_touch_swipe_gesture_detector.sv =====
// testbench for the touch swipe gesture detector: directed, config sweep, random and stall tests
`timescale 1ns / 1ps

module tb_touch_swipe_gesture_detector;
    import tsgd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int SCREEN_W       = 800;
    localparam int SCREEN_H       = 480;
    localparam int MAX_WAIT       = 12;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int EVENT_TARGET   = 1120;

    localparam int AREA_TOP    = 0;
    localparam int AREA_BOTTOM = 1;
    localparam int AREA_LEFT   = 2;
    localparam int AREA_RIGHT  = 3;

    typedef struct {
        bit          active;
        logic [31:0] start_ms;
        logic [10:0] first_x;
        logic [10:0] first_y;
        logic [10:0] last_x;
        logic [10:0] last_y;
        logic [3:0]  first_area;
        logic [2:0]  dir;
        logic [11:0] span;
        bit          slow;
    } t_gesture_state;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    tsgd_sample_if sample_ch();
    tsgd_event_if  event_ch();

    touch_swipe_gesture_detector #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (sample_ch),
        .o_event   (event_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    logic [10:0] cfg_vedge      = 11'd20;
    logic [10:0] cfg_hedge      = 11'd20;
    logic [10:0] cfg_min_vert   = 11'd50;
    logic [10:0] cfg_min_horz   = 11'd50;
    logic [13:0] cfg_tan        = 14'd256;
    logic [15:0] cfg_slow_speed = 16'd256;
    logic [15:0] cfg_short_ms   = 16'd200;

    t_gesture_state gest = '{default: '0};
    t_event         gesture_events_due[$];
    int             events_predicted = 0;
    int             error_count      = 0;
    logic [31:0]    clock_ms         = 32'd0;
    bit             tx_pace          = 1'b1;
    bit             rx_pace          = 1'b1;
    int             rx_hold_req      = 0;

    // prediction

    function automatic logic [3:0] area_of(input logic [10:0] x, input logic [10:0] y);
        logic [3:0] a;
        a = '0;
        if (y < cfg_vedge) a[AREA_TOP] = 1'b1;
        if (SCREEN_H - int'(y) < int'(cfg_vedge)) a[AREA_BOTTOM] = 1'b1;
        if (x < cfg_hedge) a[AREA_LEFT] = 1'b1;
        if (SCREEN_W - int'(x) < int'(cfg_hedge)) a[AREA_RIGHT] = 1'b1;
        return a;
    endfunction

    function automatic logic [11:0] floor_sqrt(input int unsigned v);
        logic [11:0] r;
        r = '0;
        for (int b = 11; b >= 0; b--) begin
            r[b] = 1'b1;
            if (longint'(r) * longint'(r) > longint'(v)) r[b] = 1'b0;
        end
        return r;
    endfunction

    task automatic predict_gesture_event(input logic p, input logic [10:0] x,
                                         input logic [10:0] y, input logic [31:0] stamp);
        bit          touched;
        int          dx;
        int          dy;
        int          ax;
        int          ay;
        logic [31:0] elapsed;
        t_event      ev;
        touched = p && (x < SCREEN_W) && (y < SCREEN_H);
        if (!gest.active && !touched) return;
        if (touched) begin
            gest.last_x = x;
            gest.last_y = y;
        end
        elapsed = '0;
        ev.is_short = 1'b0;
        if (!gest.active) begin
            gest.active     = 1'b1;
            gest.start_ms   = stamp;
            gest.first_x    = gest.last_x;
            gest.first_y    = gest.last_y;
            gest.first_area = area_of(gest.first_x, gest.first_y);
            ev.event_kind   = EV_PRESS;
        end else begin
            dx = int'(gest.last_x) - int'(gest.first_x);
            dy = int'(gest.last_y) - int'(gest.first_y);
            elapsed = stamp - gest.start_ms;
            ev.is_short = elapsed < {16'd0, cfg_short_ms};
            ev.event_kind = touched ? EV_PRESSING : EV_RELEASE;
            if (dx != 0 || dy != 0) begin
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                gest.span = floor_sqrt(ax * ax + ay * ay);
                gest.slow = longint'(gest.span) * 256 <
                            longint'(cfg_slow_speed) * longint'(elapsed);
                if (dx == 0 || longint'(ay) * 256 > longint'(cfg_tan) * longint'(ax)) begin
                    if (dy > int'(cfg_min_vert)) gest.dir = DIR_DOWN;
                    else if (dy < -int'(cfg_min_vert)) gest.dir = DIR_UP;
                end else begin
                    if (dx > int'(cfg_min_horz)) gest.dir = DIR_RIGHT;
                    else if (dx < -int'(cfg_min_horz)) gest.dir = DIR_LEFT;
                end
            end
        end
        ev.first_x    = gest.first_x;
        ev.first_y    = gest.first_y;
        ev.last_x     = gest.last_x;
        ev.last_y     = gest.last_y;
        ev.first_area = gest.first_area;
        ev.last_area  = area_of(gest.last_x, gest.last_y);
        ev.swipe_dir  = gest.dir;
        ev.travel_px  = gest.span;
        ev.elapsed_ms = elapsed;
        ev.is_slow    = gest.slow;
        gesture_events_due.push_back(ev);
        events_predicted++;
        if (ev.event_kind == EV_RELEASE) gest = '{default: '0};
    endtask

    // stimulus helpers

    task automatic send_sample(input logic p, input logic [10:0] x, input logic [10:0] y,
                               input logic [31:0] stamp);
        int gap;
        gap = tx_pace ? $urandom_range(0, MAX_WAIT) : 0;
        repeat (gap) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.pressed <= p;
        sample_ch.touch_x <= x;
        sample_ch.touch_y <= y;
        sample_ch.now_ms  <= stamp;
        do @(posedge i_clk); while (!sample_ch.ready);
        predict_gesture_event(p, x, y, stamp);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (gesture_events_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_VEDGE:    cfg_vedge      = value[10:0];
            CFG_HEDGE:    cfg_hedge      = value[10:0];
            CFG_MIN_VERT: cfg_min_vert   = value[10:0];
            CFG_MIN_HORZ: cfg_min_horz   = value[10:0];
            CFG_TAN:      cfg_tan        = value[13:0];
            CFG_SLOW:     cfg_slow_speed = value;
            CFG_SHORT:    cfg_short_ms   = value;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] vedge, input logic [15:0] hedge,
                                input logic [15:0] min_vert, input logic [15:0] min_horz,
                                input logic [15:0] tan_q8, input logic [15:0] slow_q8,
                                input logic [15:0] short_ms);
        write_reg(CFG_VEDGE, vedge);
        write_reg(CFG_HEDGE, hedge);
        write_reg(CFG_MIN_VERT, min_vert);
        write_reg(CFG_MIN_HORZ, min_horz);
        write_reg(CFG_TAN, tan_q8);
        write_reg(CFG_SLOW, slow_q8);
        write_reg(CFG_SHORT, short_ms);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void advance_clock();
        case ($urandom_range(0, 9))
            0:       clock_ms = clock_ms;
            1:       clock_ms = clock_ms + $urandom;
            2, 3:    clock_ms = clock_ms + $urandom_range(150, 260);
            default: clock_ms = clock_ms + $urandom_range(1, 40);
        endcase
    endfunction

    function automatic logic [10:0] pick_coord(input int span);
        case ($urandom_range(0, 4))
            0:       return 11'($urandom_range(0, 25));
            1:       return 11'(span - 1 - int'($urandom_range(0, 25)));
            default: return 11'($urandom_range(0, span - 1));
        endcase
    endfunction

    function automatic logic [10:0] clamp_px(input int v, input int span);
        if (v < 0) return '0;
        if (v >= span) return 11'(span - 1);
        return 11'(v);
    endfunction

    task automatic pick_move(input logic [10:0] sx, input logic [10:0] sy,
                             output logic [10:0] x, output logic [10:0] y);
        int dx;
        int dy;
        case ($urandom_range(0, 5))
            0: begin
                dx = 0;
                dy = int'($urandom_range(0, 600)) - 300;
            end
            1: begin
                dx = int'($urandom_range(0, 800)) - 400;
                dy = 0;
            end
            2: begin
                dx = int'($urandom_range(0, 120)) - 60;
                dy = int'($urandom_range(0, 120)) - 60;
            end
            3: begin
                dx = 0;
                dy = 0;
            end
            default: begin
                dx = int'($urandom_range(0, 1598)) - 799;
                dy = int'($urandom_range(0, 958)) - 479;
            end
        endcase
        x = clamp_px(int'(sx) + dx, SCREEN_W);
        y = clamp_px(int'(sy) + dy, SCREEN_H);
    endtask

    task automatic send_gesture(input int moves);
        logic [10:0] sx;
        logic [10:0] sy;
        logic [10:0] x;
        logic [10:0] y;
        sx = pick_coord(SCREEN_W);
        sy = pick_coord(SCREEN_H);
        // samples ignored while no gesture is active
        if ($urandom_range(0, 7) == 0)
            send_sample(1'($urandom_range(0, 1)), 11'($urandom_range(SCREEN_W, 2047)),
                        11'($urandom_range(0, 2047)), $urandom);
        if ($urandom_range(0, 7) == 0)
            send_sample(1'b0, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                        $urandom);
        send_sample(1'b1, sx, sy, clock_ms);
        for (int i = 0; i < moves; i++) begin
            advance_clock();
            if ($urandom_range(0, 15) == 0) break;
            pick_move(sx, sy, x, y);
            send_sample(1'b1, x, y, clock_ms);
        end
        advance_clock();
        if ($urandom_range(0, 3) == 0)
            send_sample(1'b1, 11'($urandom_range(0, 2047)),
                        11'($urandom_range(SCREEN_H, 2047)), clock_ms);
        else
            send_sample(1'b0, 11'($urandom_range(0, 2047)),
                        11'($urandom_range(0, 2047)), clock_ms);
    endtask

    // tests

    task automatic test_directed();
        send_sample(1'b0, 11'd0, 11'd0, 32'd0);
        send_sample(1'b1, 11'd800, 11'd100, 32'd5);
        send_sample(1'b1, 11'd100, 11'd480, 32'd6);
        send_sample(1'b1, 11'd2047, 11'd2047, 32'd7);
        send_sample(1'b1, 11'd0, 11'd0, 32'd10);
        send_sample(1'b1, 11'd0, 11'd0, 32'd10);
        send_sample(1'b1, 11'd799, 11'd479, 32'd20);
        send_sample(1'b0, 11'd2047, 11'd2047, 32'hFFFF_FFFF);
        send_sample(1'b1, 11'd400, 11'd240, 32'hFFFF_FFF0);
        send_sample(1'b1, 11'd400, 11'd100, 32'h0000_0010);
        send_sample(1'b1, 11'd410, 11'd230, 32'h0000_0020);
        send_sample(1'b1, 11'd400, 11'd240, 32'h0000_0030);
        send_sample(1'b1, 11'd900, 11'd240, 32'h0000_0040);
        send_sample(1'b1, 11'd400, 11'd240, 32'd1000);
        send_sample(1'b1, 11'd400, 11'd400, 32'd1000);
        send_sample(1'b1, 11'd300, 11'd410, 32'd1300);
        send_sample(1'b1, 11'd200, 11'd250, 32'd5000);
        send_sample(1'b0, 11'd0, 11'd0, 32'd70000);
        send_sample(1'b1, 11'd780, 11'd470, 32'd2000);
        send_sample(1'b1, 11'd781, 11'd471, 32'd2001);
        send_sample(1'b1, 11'd400, 11'd480, 32'd2100);
        send_sample(1'b0, 11'd400, 11'd240, 32'd3000);
        wait_idle();
    endtask

    task automatic test_config_sweep();
        apply_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd4, 16'd1, 16'd1);
        repeat (6) send_gesture($urandom_range(1, 6));
        wait_idle();
        apply_config(16'd2047, 16'd2047, 16'd2047, 16'd2047, 16'd16383, 16'd65535, 16'd65535);
        repeat (6) send_gesture($urandom_range(1, 6));
        wait_idle();
        apply_config(16'd20, 16'd300, 16'd10, 16'd400, 16'd14667, 16'd32768, 16'd1000);
        repeat (6) send_gesture($urandom_range(1, 6));
        repeat (3) begin
            wait_idle();
            apply_config(16'($urandom_range(1, 2047)), 16'($urandom_range(1, 2047)),
                         16'($urandom_range(1, 2047)), 16'($urandom_range(1, 2047)),
                         16'($urandom_range(4, 16383)), 16'($urandom_range(1, 65535)),
                         16'($urandom_range(1, 65535)));
            repeat (6) send_gesture($urandom_range(1, 6));
        end
        wait_idle();
        apply_config(16'd20, 16'd20, 16'd50, 16'd50, 16'd256, 16'd256, 16'd200);
    endtask

    task automatic test_random();
        while (events_predicted < EVENT_TARGET) begin
            tx_pace = $urandom_range(0, 3) != 0;
            rx_pace = $urandom_range(0, 3) != 0;
            send_gesture($urandom_range(0, 8));
        end
        tx_pace = 1'b1;
        rx_pace = 1'b1;
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_pace     = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        send_gesture(12);
        send_gesture(12);
        tx_pace = 1'b1;
        wait_idle();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        sample_ch.valid   <= 1'b0;
        sample_ch.pressed <= 1'b0;
        sample_ch.touch_x <= '0;
        sample_ch.touch_y <= '0;
        sample_ch.now_ms  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_random();
        test_backpressure();
        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // event receiver with per-transfer stalls and an optional long hold-off
    initial begin : event_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        event_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (event_ch.valid && event_ch.ready)
                stall_left = rx_pace ? $urandom_range(0, MAX_WAIT) : 0;
            else if (stall_left > 0)
                stall_left--;
            if (hold_left > 0) hold_left--;
            event_ch.ready <= (hold_left == 0) && (stall_left == 0);
        end
    end

    // checking

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : event_check
        t_event want;
        if (i_rst_n && event_ch.valid && event_ch.ready) begin
            if (gesture_events_due.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual kind %0d",
                         $time, event_ch.event_kind);
                error_count++;
            end else begin
                want = gesture_events_due.pop_front();
                compare_field("event_kind", want.event_kind, event_ch.event_kind);
                compare_field("first_x", want.first_x, event_ch.first_x);
                compare_field("first_y", want.first_y, event_ch.first_y);
                compare_field("last_x", want.last_x, event_ch.last_x);
                compare_field("last_y", want.last_y, event_ch.last_y);
                compare_field("first_area", want.first_area, event_ch.first_area);
                compare_field("last_area", want.last_area, event_ch.last_area);
                compare_field("swipe_dir", want.swipe_dir, event_ch.swipe_dir);
                compare_field("travel_px", want.travel_px, event_ch.travel_px);
                compare_field("elapsed_ms", want.elapsed_ms, event_ch.elapsed_ms);
                compare_field("is_short", want.is_short, event_ch.is_short);
                compare_field("is_slow", want.is_slow, event_ch.is_slow);
            end
        end
    end

    // cycles without any transfer
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
design/tsgd_pkg.sv
design/tsgd_sample_if.sv
design/tsgd_event_if.sv
design/tsgd_isqrt.sv
design/touch_swipe_gesture_detector.sv
tb/tb_touch_swipe_gesture_detector.sv
